[sv/sample_statistics_mean_sd_max_assert.svh]
// Assertion macros shared by the sample statistics checker.
`ifndef SAMPLE_STATISTICS_MEAN_SD_MAX_ASSERT_SVH
`define SAMPLE_STATISTICS_MEAN_SD_MAX_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSMSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sample statistics assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSMSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sample statistics assertion failed");

`endif

[sv/ssmsd_pkg.sv]
// Package with the constants and status codes of the sample statistics block.
package ssmsd_pkg;

  localparam int VAL_W   = 30;
  localparam int SQRT_W  = 64;
  localparam int ROOT_W  = SQRT_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int UNIT_W  = REM_W + 2;

  localparam logic [VAL_W-1:0] MIN_RESET = VAL_W'(1);
  localparam logic [VAL_W-1:0] MAX_RESET = VAL_W'(1000000000);

  localparam logic REG_MIN_IDX = 1'b0;
  localparam logic REG_MAX_IDX = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t VSTAT_ACCEPT = 2'd0;
  localparam status_t VSTAT_RANGE  = 2'd1;
  localparam status_t VSTAT_FULL   = 2'd2;

  localparam status_t SSTAT_NONE  = 2'd0;
  localparam status_t SSTAT_VALID = 2'd1;
  localparam status_t SSTAT_FEW   = 2'd2;

endpackage

[sv/ssmsd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ssmsd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/sample_statistics_mean_sd_max.sv]
// Top level of the sample statistics block: store, sequencer and shared unit.
//
//   channel   ports                          handshake
//   input     in_value_milliohm, in_last     start high and busy low
//   result    out_* fields                   out_valid strobe, one cycle
//   config    psel, penable, pwrite, paddr   APB write, pready always high
//
// An item that is not marked last gives its result in the next cycle, and the
// block takes a new transaction in that same cycle. A last item over fewer
// than two values does the same. A last item over N >= 2 values keeps busy
// high through the sum, division, deviation and root passes: one
// compare-subtract unit yields one quotient bit or one root bit per cycle.
// Reset is synchronous; it clears the count and loads the window limits
// with their reset values. Results are never held off by the receiver.
module sample_statistics_mean_sd_max
  import ssmsd_pkg::*;
#(
  parameter int MAX_VALUES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [VAL_W-1:0]                     in_value_milliohm,
  input  logic                                 in_last,
  output logic                                 out_valid,
  output logic [1:0]                           out_value_status,
  output logic [1:0]                           out_stats_status,
  output logic [VAL_W-1:0]                     out_mean_milliohm,
  output logic [VAL_W-1:0]                     out_std_dev_milliohm,
  output logic [VAL_W-1:0]                     out_largest_milliohm,
  output logic [$clog2(MAX_VALUES+1)-1:0]      out_value_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int CW   = $clog2(MAX_VALUES + 1);
  localparam int AW   = $clog2(MAX_VALUES);
  localparam int SUMW = VAL_W + CW;
  localparam int SQW  = 2 * VAL_W + CW;
  localparam int ACCW = (SQW > SQRT_W) ? SQW : SQRT_W;
  localparam int ITW  = $clog2(ACCW);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_DIVM, ST_DEV, ST_DIVV, ST_SQRT
  } state_t;

  state_t               state_r;
  logic [VAL_W-1:0]     min_r, max_r;
  logic [CW-1:0]        count_r, n_r, rd_idx_r;
  logic                 rd_vld_r, d_vld_r, sq_vld_r;
  logic [SUMW-1:0]      sum_r;
  logic [VAL_W-1:0]     big_r, mean_r, d_r;
  logic [2*VAL_W-1:0]   sq_r;
  logic [ACCW-1:0]      acc_r, shift_r, shift_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [ITW-1:0]       iter_r;

  logic                 out_valid_r;
  status_t              out_vstat_r, out_sstat_r;
  logic [VAL_W-1:0]     out_mean_r, out_sd_r, out_big_r;
  logic [CW-1:0]        out_count_r;

  logic                 accept, out_range, full, store_ok, cfg_wr;
  status_t              vstat;
  logic [CW-1:0]        cnt_after, divisor;
  logic                 rd_issue;
  logic [VAL_W-1:0]     rdata;

  logic [UNIT_W-1:0]    unit_a, unit_b;
  logic [UNIT_W:0]      unit_diff;
  logic                 unit_ge;
  logic                 is_div;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_range = (in_value_milliohm < min_r) || (in_value_milliohm > max_r);
  assign full      = (count_r >= CW'(MAX_VALUES));
  assign store_ok  = accept && !out_range && !full;
  assign vstat     = out_range ? VSTAT_RANGE : (full ? VSTAT_FULL : VSTAT_ACCEPT);
  assign cnt_after = count_r + CW'(store_ok);

  // Reads are issued in the pass over the set, both for the sum and for the deviations.
  assign rd_issue  = ((state_r == ST_SUM) || (state_r == ST_DEV)) && (rd_idx_r < n_r);

  ssmsd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_VALUES)
  ) u_store (
    .clk   (clk),
    .we    (store_ok),
    .waddr (count_r[AW-1:0]),
    .wdata (in_value_milliohm),
    .re    (rd_issue),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // Shared compare-subtract unit: restoring division step or square root step.
  assign is_div  = (state_r == ST_DIVM) || (state_r == ST_DIVV);
  assign divisor = (state_r == ST_DIVM) ? n_r : (n_r - CW'(1));

  always_comb begin
    if (is_div) begin
      unit_a = UNIT_W'({rem_r[CW-1:0], shift_r[ACCW-1]});
      unit_b = UNIT_W'(divisor);
    end else begin
      unit_a = {rem_r, shift_r[ACCW-1 -: 2]};
      unit_b = UNIT_W'({root_r, 2'b01});
    end
    unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    unit_ge   = !unit_diff[UNIT_W];
    if (is_div) begin
      rem_nxt   = unit_ge ? REM_W'(unit_diff[CW-1:0]) : REM_W'(unit_a[CW-1:0]);
      shift_nxt = {shift_r[ACCW-2:0], unit_ge};
      root_nxt  = root_r;
    end else begin
      rem_nxt   = unit_ge ? unit_diff[REM_W-1:0] : unit_a[REM_W-1:0];
      shift_nxt = {shift_r[ACCW-3:0], 2'b00};
      root_nxt  = {root_r[ROOT_W-2:0], unit_ge};
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_IDX) ? 32'(max_r) : 32'(min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      d_vld_r     <= 1'b0;
      sq_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == REG_MIN_IDX) begin
          min_r <= pwdata[VAL_W-1:0];
        end else begin
          max_r <= pwdata[VAL_W-1:0];
        end
      end
      rd_vld_r <= rd_issue;
      d_vld_r  <= rd_vld_r && (state_r == ST_DEV);
      sq_vld_r <= d_vld_r;
      if (rd_issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (d_vld_r) begin
        sq_r <= d_r * d_r;
      end
      if (sq_vld_r) begin
        acc_r <= acc_r + ACCW'(sq_r);
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_vstat_r <= vstat;
            out_count_r <= cnt_after;
            out_mean_r  <= '0;
            out_sd_r    <= '0;
            out_big_r   <= '0;
            n_r         <= cnt_after;
            if (!in_last) begin
              count_r     <= cnt_after;
              out_sstat_r <= SSTAT_NONE;
              out_valid_r <= 1'b1;
            end else begin
              count_r <= '0;
              if (cnt_after < CW'(2)) begin
                out_sstat_r <= SSTAT_FEW;
                out_valid_r <= 1'b1;
              end else begin
                rd_idx_r <= '0;
                sum_r    <= '0;
                big_r    <= '0;
                state_r  <= ST_SUM;
              end
            end
          end
        end
        ST_SUM: begin
          if (rd_vld_r) begin
            sum_r <= sum_r + SUMW'(rdata);
            if (rdata > big_r) begin
              big_r <= rdata;
            end
          end else if (rd_idx_r == n_r) begin
            shift_r <= ACCW'(sum_r);
            rem_r   <= '0;
            iter_r  <= ITW'(ACCW - 1);
            state_r <= ST_DIVM;
          end
        end
        ST_DIVM: begin
          shift_r <= shift_nxt;
          rem_r   <= rem_nxt;
          iter_r  <= iter_r - ITW'(1);
          if (iter_r == '0) begin
            mean_r   <= shift_nxt[VAL_W-1:0];
            rd_idx_r <= '0;
            acc_r    <= '0;
            state_r  <= ST_DEV;
          end
        end
        ST_DEV: begin
          if (rd_vld_r) begin
            d_r <= (rdata >= mean_r) ? (rdata - mean_r) : (mean_r - rdata);
          end
          if (!rd_vld_r && !d_vld_r && !sq_vld_r && (rd_idx_r == n_r)) begin
            shift_r <= acc_r;
            rem_r   <= '0;
            iter_r  <= ITW'(ACCW - 1);
            state_r <= ST_DIVV;
          end
        end
        ST_DIVV: begin
          iter_r <= iter_r - ITW'(1);
          if (iter_r == '0) begin
            // Line the low 64 quotient bits up at the top for the root pass.
            shift_r <= shift_nxt << (ACCW - SQRT_W);
            rem_r   <= '0;
            root_r  <= '0;
            iter_r  <= ITW'(ROOT_W - 1);
            state_r <= ST_SQRT;
          end else begin
            shift_r <= shift_nxt;
            rem_r   <= rem_nxt;
          end
        end
        ST_SQRT: begin
          shift_r <= shift_nxt;
          rem_r   <= rem_nxt;
          root_r  <= root_nxt;
          iter_r  <= iter_r - ITW'(1);
          if (iter_r == '0) begin
            out_sd_r    <= (root_nxt[ROOT_W-1:VAL_W] != '0) ? '1 : root_nxt[VAL_W-1:0];
            out_mean_r  <= mean_r;
            out_big_r   <= big_r;
            out_sstat_r <= SSTAT_VALID;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_value_status     = out_vstat_r;
  assign out_stats_status     = out_sstat_r;
  assign out_mean_milliohm    = out_mean_r;
  assign out_std_dev_milliohm = out_sd_r;
  assign out_largest_milliohm = out_big_r;
  assign out_value_count      = out_count_r;

endmodule

[sv/ssmsd_checker.sv]
// Port-level checker for the sample statistics block, with its bind.
`include "sample_statistics_mean_sd_max_assert.svh"

module ssmsd_checker
  import ssmsd_pkg::*;
#(
  parameter int MAX_VALUES = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            in_last,
  input logic                            out_valid,
  input logic [1:0]                      out_value_status,
  input logic [1:0]                      out_stats_status,
  input logic [VAL_W-1:0]                out_mean_milliohm,
  input logic [VAL_W-1:0]                out_std_dev_milliohm,
  input logic [VAL_W-1:0]                out_largest_milliohm,
  input logic [$clog2(MAX_VALUES+1)-1:0] out_value_count
);

  localparam int CW = $clog2(MAX_VALUES + 1);

  // A transaction that does not end a set is answered in the very next cycle.
  `SSMSD_ASSERT_NEXT(a_item_answered, start && !busy && !in_last, out_valid)

  // Entering the statistics sequence never coincides with a result.
  `SSMSD_ASSERT_IMPL(a_busy_quiet, $rose(busy), !out_valid)

  // Without valid statistics the statistic fields read as zero.
  `SSMSD_ASSERT_IMPL(a_stats_zero, out_valid && (out_stats_status != SSTAT_VALID),
    (out_mean_milliohm == '0) && (out_std_dev_milliohm == '0) &&
    (out_largest_milliohm == '0))

  // Valid statistics come from at least two values, and the largest bounds the mean.
  `SSMSD_ASSERT_IMPL(a_stats_sane, out_valid && (out_stats_status == SSTAT_VALID),
    (out_value_count >= CW'(2)) && (out_value_count <= CW'(MAX_VALUES)) &&
    (out_largest_milliohm >= out_mean_milliohm))

  // An accepted value is always counted, so the reported count is not zero.
  `SSMSD_ASSERT_IMPL(a_accept_counts, out_valid && (out_value_status == VSTAT_ACCEPT),
    out_value_count != '0)

endmodule

bind sample_statistics_mean_sd_max ssmsd_checker #(.MAX_VALUES(MAX_VALUES)) u_checker (.*);

[tb/sample_statistics_mean_sd_max_tb.sv]
// Self-checking testbench for the sample statistics block: mean, sample deviation, largest value.
import ssmsd_pkg::*;

localparam int unsigned STORE_DEPTH = 16;
localparam logic [VAL_W-1:0] VAL_MAX = '1;

typedef struct {
  status_t          vstat;
  status_t          sstat;
  logic [VAL_W-1:0] mean;
  logic [VAL_W-1:0] sd;
  logic [VAL_W-1:0] big;
  logic [4:0]       count;
} stats_result_t;

class stats_scoreboard;
  logic [VAL_W-1:0] lo_limit;
  logic [VAL_W-1:0] hi_limit;
  logic [VAL_W-1:0] samples [STORE_DEPTH];
  int unsigned      n_stored;
  int unsigned      fails;
  stats_result_t    awaited_stats [$];

  function new();
    lo_limit = MIN_RESET;
    hi_limit = MAX_RESET;
    n_stored = 0;
    fails = 0;
  endfunction

  function void set_limit(logic idx, logic [VAL_W-1:0] val);
    if (idx == REG_MIN_IDX) begin
      lo_limit = val;
    end else begin
      hi_limit = val;
    end
  endfunction

  function logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function void note_item(logic [VAL_W-1:0] v, logic fin);
    stats_result_t    r;
    logic [63:0]      total;
    logic [63:0]      avg;
    logic [127:0]     dev;
    logic [127:0]     dev_sq;
    logic [127:0]     quo;
    logic [63:0]      root;
    logic [VAL_W-1:0] peak;
    r.mean = '0;
    r.sd = '0;
    r.big = '0;
    r.sstat = SSTAT_NONE;
    // A value outside the window is reported as such even when the store is full.
    if (v < lo_limit || v > hi_limit) begin
      r.vstat = VSTAT_RANGE;
    end else if (n_stored >= STORE_DEPTH) begin
      r.vstat = VSTAT_FULL;
    end else begin
      samples[n_stored] = v;
      n_stored++;
      r.vstat = VSTAT_ACCEPT;
    end
    r.count = 5'(n_stored);
    if (fin) begin
      if (n_stored < 2) begin
        r.sstat = SSTAT_FEW;
      end else begin
        total = '0;
        peak = '0;
        for (int i = 0; i < n_stored; i++) begin
          total += samples[i];
          if (samples[i] > peak) peak = samples[i];
        end
        avg = total / n_stored;
        dev_sq = '0;
        for (int i = 0; i < n_stored; i++) begin
          dev = (samples[i] >= avg) ? samples[i] - avg : avg - samples[i];
          dev_sq += dev * dev;
        end
        quo = dev_sq / (n_stored - 1);
        root = floor_sqrt(quo[63:0]);
        if (root > VAL_MAX) root = VAL_MAX;
        r.mean = avg[VAL_W-1:0];
        r.sd = root[VAL_W-1:0];
        r.big = peak;
        r.sstat = SSTAT_VALID;
      end
      n_stored = 0;
    end
    awaited_stats.push_back(r);
  endfunction

  function void check_result(stats_result_t got);
    stats_result_t want;
    if (awaited_stats.size() == 0) begin
      $error("result strobe with no transaction outstanding");
      fails++;
      return;
    end
    want = awaited_stats.pop_front();
    if (got.vstat !== want.vstat) begin
      $error("value_status: expected %0d, got %0d", want.vstat, got.vstat);
      fails++;
    end
    if (got.sstat !== want.sstat) begin
      $error("stats_status: expected %0d, got %0d", want.sstat, got.sstat);
      fails++;
    end
    if (got.mean !== want.mean) begin
      $error("mean_milliohm: expected %0d, got %0d", want.mean, got.mean);
      fails++;
    end
    if (got.sd !== want.sd) begin
      $error("std_dev_milliohm: expected %0d, got %0d", want.sd, got.sd);
      fails++;
    end
    if (got.big !== want.big) begin
      $error("largest_milliohm: expected %0d, got %0d", want.big, got.big);
      fails++;
    end
    if (got.count !== want.count) begin
      $error("value_count: expected %0d, got %0d", want.count, got.count);
      fails++;
    end
  endfunction
endclass

module sample_statistics_mean_sd_max_tb;
  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned QUIET_FROM  = 700;
  localparam int unsigned QUIET_TO    = 1100;
  localparam int unsigned STALL_LIMIT = 20000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [VAL_W-1:0] in_value_milliohm;
  logic             in_last;
  logic             out_valid;
  logic [1:0]       out_value_status;
  logic [1:0]       out_stats_status;
  logic [VAL_W-1:0] out_mean_milliohm;
  logic [VAL_W-1:0] out_std_dev_milliohm;
  logic [VAL_W-1:0] out_largest_milliohm;
  logic [4:0]       out_value_count;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  stats_scoreboard book;
  int unsigned     items_sent = 0;
  int unsigned     stall_cycles = 0;

  sample_statistics_mean_sd_max #(
    .MAX_VALUES(STORE_DEPTH)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_value_milliohm   (in_value_milliohm),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_value_status    (out_value_status),
    .out_stats_status    (out_stats_status),
    .out_mean_milliohm   (out_mean_milliohm),
    .out_std_dev_milliohm(out_std_dev_milliohm),
    .out_largest_milliohm(out_largest_milliohm),
    .out_value_count     (out_value_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #2 clk = ~clk;

  task automatic idle_for(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_value(logic [VAL_W-1:0] v, logic fin);
    if (items_sent < QUIET_FROM || items_sent >= QUIET_TO) begin
      // Each cycle is idle with a chance of 28 in a hundred.
      while ($urandom_range(99) < 28) idle_for(1);
    end
    start <= 1'b1;
    in_value_milliohm <= v;
    in_last <= fin;
    do @(posedge clk); while (busy);
    book.note_item(v, fin);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (book.awaited_stats.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic idx, logic [VAL_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {2'($urandom_range(3)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    book.set_limit(idx, val);
    @(posedge clk);
  endtask

  task automatic set_window(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
    drain();
    put_reg(REG_MIN_IDX, lo);
    put_reg(REG_MAX_IDX, hi);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    int unsigned      roll;
    lo = book.lo_limit;
    hi = book.hi_limit;
    roll = $urandom_range(19);
    if (roll < 2) return VAL_W'($urandom);
    if (roll == 2) return (lo == '0) ? lo : lo - VAL_W'(1);
    if (roll == 3) return (hi == VAL_MAX) ? hi : hi + VAL_W'(1);
    if (roll == 4) return lo;
    if (roll == 5) return hi;
    if (lo > hi) return VAL_W'($urandom);
    return VAL_W'($urandom_range(hi, lo));
  endfunction

  always @(posedge clk) begin : result_monitor
    stats_result_t seen;
    if (rst_n && out_valid) begin
      seen.vstat = out_value_status;
      seen.sstat = out_stats_status;
      seen.mean = out_mean_milliohm;
      seen.sd = out_std_dev_milliohm;
      seen.big = out_largest_milliohm;
      seen.count = out_value_count;
      book.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sample_statistics_mean_sd_max: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned      sets_left;
    int unsigned      len;
    logic [VAL_W-1:0] lo;
    book = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_value_milliohm <= '0;
    in_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window: empty set, a single value, and a two-value set around a rejected value.
    send_value(VAL_W'(0), 1'b1);
    send_value(MIN_RESET, 1'b1);
    send_value(MAX_RESET, 1'b0);
    send_value(MAX_RESET + VAL_W'(1), 1'b0);
    send_value(VAL_W'(500), 1'b1);
    // Fill the store, then overflow it in range and out of range.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_value(VAL_W'($urandom_range(MAX_RESET, MIN_RESET)), 1'b0);
    end
    send_value(VAL_W'(7), 1'b0);
    send_value(VAL_W'(0), 1'b0);
    send_value(VAL_MAX, 1'b1);
    // Widest possible window, then an inverted one that turns everything away.
    set_window(VAL_W'(0), VAL_MAX);
    send_value(VAL_W'(0), 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MAX, 1'b1);
    set_window(VAL_W'(600), VAL_W'(500));
    send_value(VAL_W'(550), 1'b0);
    send_value(VAL_W'(550), 1'b1);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        0: set_window(VAL_W'(0), VAL_MAX);
        1: begin
          lo = VAL_W'($urandom_range(VAL_MAX, 1));
          set_window(lo, VAL_W'($urandom_range(lo - 1)));
        end
        2: begin
          lo = VAL_W'($urandom_range(VAL_MAX - 5000));
          set_window(lo, lo + VAL_W'($urandom_range(5000)));
        end
        3: set_window(MIN_RESET, MAX_RESET);
        default: set_window(VAL_W'($urandom_range(1 << 20)),
                            VAL_W'($urandom_range(VAL_MAX, 1 << 29)));
      endcase
      sets_left = $urandom_range(12, 4);
      while (sets_left > 0 && items_sent < ITEM_TARGET) begin
        if ($urandom_range(9) == 0) begin
          // Loose items with random marking.
          len = $urandom_range(6, 1);
          for (int k = 0; k < len; k++) begin
            send_value(VAL_W'($urandom), $urandom_range(2) == 0);
          end
        end else begin
          len = ($urandom_range(7) == 0) ? $urandom_range(19, 14) : $urandom_range(10, 0);
          for (int k = 0; k < len; k++) send_value(pick_value(), 1'b0);
          send_value(pick_value(), 1'b1);
        end
        if ($urandom_range(19) == 0) drain();
        sets_left--;
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (book.fails == 0) begin
      $display("sample_statistics_mean_sd_max: match");
    end else begin
      $display("sample_statistics_mean_sd_max: mismatch");
    end
    $finish;
  end
endmodule
